### hw/rtl/bns_pkg.sv
// bounded neighbor set package: word types, action and status codes, size defaults
// no dependencies
`default_nettype none
package bns_pkg;

   localparam int ID_WIDTH         = 24;
   localparam int COUNT_WIDTH      = 7;
   localparam int SET_CAPACITY_DEF = 16;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NO_CHANGE = 2'd1;
   localparam logic [1:0] ST_REJECT    = 2'd2;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [ID_WIDTH-1:0] vertex_id;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   is_member;
      logic [COUNT_WIDTH-1:0] entry_total;
   } rsp_word_type;

endpackage
`default_nettype wire

### hw/rtl/bns_ram.sv
// generic simple dual-port ram, one write port, one read port with registered data
// no dependencies
`default_nettype none
module bns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/bounded_neighbor_set.sv
// bounded neighbor set top level: set of vertex ids packed in a ram, scan and compaction control
// depends on bns_pkg and bns_ram
//
//  port group   dir  handshake              word
//  req_         in   req_valid/req_ready    req_word_type (action, vertex_id)
//  rsp_         out  rsp_valid/rsp_ready    rsp_word_type (status, is_member, entry_total)
//
// an add, delete or query with a non-negative id passes from accept to the next accept through
// one ram read per stored slot (none when the set is empty), the registered read data, a
// check that the scan has drained, the finish state and the idle state that takes the word
// a negative id or unused action goes from idle straight to the finish state and back
// delete moves each later slot down one place during the same scan
// reset clears the count and control only; slot contents are never cleared
// a pending response does not block the next item until its finish cycle
`default_nettype none
module bounded_neighbor_set
   import bns_pkg::*;
#(
   parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   localparam int ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
   localparam int MAG_W  = ID_WIDTH - 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       action_ff, action_in;
   logic [MAG_W-1:0] id_ff, id_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic              rd_en;
   logic [MAG_W-1:0]  rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MAG_W-1:0]  wr_data;
   logic              hit;

   bns_ram #(
      .WIDTH (MAG_W),
      .DEPTH (SET_CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign hit       = rd_valid_ff && (rd_data == id_ff);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      id_in        = id_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_valid_in  = 1'b0;
      rd_addr_in   = rd_addr_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = ADDR_W'(rd_addr_ff - 1'b1);
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in = req_word.action;
               id_in     = req_word.vertex_id[MAG_W-1:0];
               neg_in    = req_word.vertex_id[ID_WIDTH-1];
               found_in  = 1'b0;
               rd_ptr_in = '0;
               if (req_word.action inside {ACT_ADD, ACT_DELETE, ACT_QUERY}
                   && !req_word.vertex_id[ID_WIDTH-1]) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (rd_ptr_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_addr_in  = rd_ptr_ff[ADDR_W-1:0];
               rd_ptr_in   = rd_ptr_ff + 1'b1;
            end
            // shift later slots down one place once the match is behind us
            if (rd_valid_ff && found_ff && action_ff == ACT_DELETE) begin
               wr_en = 1'b1;
            end
            if (hit) begin
               found_in = 1'b1;
            end
            if (!(rd_ptr_ff < count_ff) && !rd_valid_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.is_member = 1'b0;
               rsp_word_in.status    = ST_NO_CHANGE;
               case (action_ff)
                  ACT_ADD: begin
                     if (neg_ff) begin
                        rsp_word_in.status = ST_REJECT;
                     end else if (found_ff) begin
                        rsp_word_in.status = ST_NO_CHANGE;
                     end else if (count_ff >= CNT_W'(SET_CAPACITY)) begin
                        rsp_word_in.status = ST_REJECT;
                     end else begin
                        rsp_word_in.status = ST_DONE;
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = id_ff;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (neg_ff) begin
                        rsp_word_in.status = ST_REJECT;
                     end else if (!found_ff) begin
                        rsp_word_in.status = ST_NO_CHANGE;
                     end else begin
                        rsp_word_in.status = ST_DONE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     rsp_word_in.status    = ST_DONE;
                     rsp_word_in.is_member = found_ff;
                  end
                  default: begin
                     rsp_word_in.status = ST_NO_CHANGE;
                  end
               endcase
               rsp_word_in.entry_total = COUNT_WIDTH'(count_in);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      id_ff       <= id_in;
      neg_ff      <= neg_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_word_ff <= rsp_word_in;
   end

   // count stays within the slot store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SET_CAPACITY))
      else $error("stored count above capacity");

   // scan pointer never passes the stored count
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (rd_ptr_ff <= count_ff))
      else $error("scan pointer past stored count");

   // ram writes only during compaction or the add in the finish cycle
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_SCAN && action_ff == ACT_DELETE && found_ff)
                 || (state_ff == S_FINISH && action_ff == ACT_ADD)))
      else $error("slot write outside scan or finish");

   // no read data in flight while waiting for the next word
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rd_valid_ff)
      else $error("read in flight while idle");

endmodule
`default_nettype wire

### sim/bounded_neighbor_set_test.sv
// testbench for bounded_neighbor_set: directed and random add, delete, query and unused-action words,
// checked against a predictor of the set held in this file
// depends on bns_pkg and the bounded_neighbor_set rtl
`timescale 1ns / 100ps
module bounded_neighbor_set_test;
   import bns_pkg::*;

   localparam int CAPACITY = SET_CAPACITY_DEF;
   localparam int MAG_BITS = ID_WIDTH - 1;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = CAPACITY + 8;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_word;

   logic [MAG_BITS-1:0] stored_ids [CAPACITY];
   int                  stored_total = 0;
   rsp_word_type        pending_rsp [$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  gaps_on = 1'b1;

   bounded_neighbor_set uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // updates the set and returns the response word for one request word
   function automatic rsp_word_type apply_set_op(req_word_type w);
      rsp_word_type        r;
      logic                negative;
      logic [MAG_BITS-1:0] id;
      int                  pos;
      negative = w.vertex_id[ID_WIDTH-1];
      id = w.vertex_id[MAG_BITS-1:0];
      pos = -1;
      for (int i = 0; i < stored_total; i++)
         if (pos < 0 && stored_ids[i] == id) pos = i;
      r.status = ST_NO_CHANGE;
      r.is_member = 1'b0;
      case (w.action)
         ACT_ADD: begin
            if (negative) r.status = ST_REJECT;
            else if (pos >= 0) r.status = ST_NO_CHANGE;
            else if (stored_total >= CAPACITY) r.status = ST_REJECT;
            else begin
               stored_ids[stored_total] = id;
               stored_total++;
               r.status = ST_DONE;
            end
         end
         ACT_DELETE: begin
            if (negative) r.status = ST_REJECT;
            else if (pos < 0) r.status = ST_NO_CHANGE;
            else begin
               for (int i = pos; i + 1 < stored_total; i++)
                  stored_ids[i] = stored_ids[i+1];
               stored_total--;
               r.status = ST_DONE;
            end
         end
         ACT_QUERY: begin
            r.status = ST_DONE;
            r.is_member = !negative && pos >= 0;
         end
         default: ;
      endcase
      r.entry_total = COUNT_WIDTH'(stored_total);
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [1:0] action, input logic signed [ID_WIDTH-1:0] id);
      req_word_type w;
      rsp_word_type exp_word;
      int           gap;
      w.action = action;
      w.vertex_id = id;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      exp_word = apply_set_op(w);
      pending_rsp = {pending_rsp, exp_word};
      @(negedge clock);
   endtask

   task automatic test_basic_ops;
      send_word(ACT_ADD, 0);
      send_word(ACT_ADD, 24'sd8388607);
      send_word(ACT_ADD, 0);
      send_word(ACT_QUERY, 24'sd8388607);
      send_word(ACT_QUERY, -1);
      send_word(ACT_QUERY, 7);
      send_word(ACT_ADD, -1);
      send_word(ACT_DELETE, -24'sd8388608);
      send_word(ACT_DELETE, 5);
      send_word(ACT_DELETE, 0);
      send_word(ACT_UNUSED, 24'sd8388607);
      send_word(ACT_QUERY, 0);
   endtask

   task automatic test_fill_to_capacity;
      for (int i = 1; i < CAPACITY; i++) send_word(ACT_ADD, ID_WIDTH'(i));
      send_word(ACT_ADD, 100);
      send_word(ACT_ADD, 5);
      send_word(ACT_DELETE, 1);
      send_word(ACT_DELETE, ID_WIDTH'(CAPACITY - 1));
      send_word(ACT_DELETE, 24'sd8388607);
      send_word(ACT_QUERY, 8);
      send_word(ACT_ADD, 100);
   endtask

   // ids mostly from a small pool so that matches, duplicates and a full set are common
   task automatic test_random_traffic(input int words, input int add_pct, input int del_pct,
                                      input int wide_pct, input bit with_gaps);
      logic [1:0]                 action;
      logic signed [ID_WIDTH-1:0] id;
      int                         pick;
      gaps_on = with_gaps;
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < add_pct) action = ACT_ADD;
         else if (pick < add_pct + del_pct) action = ACT_DELETE;
         else if (pick < 97) action = ACT_QUERY;
         else action = ACT_UNUSED;
         pick = $urandom_range(0, 99);
         if (pick < 8) id = {1'b1, MAG_BITS'($urandom)};
         else if (pick < 8 + wide_pct) id = {1'b0, MAG_BITS'($urandom)};
         else id = ID_WIDTH'($urandom_range(0, 23));
         send_word(action, id);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      rsp_word_type exp_rsp;
      int           stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = gaps_on ? $urandom_range(0, 6) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response word, expected none, actual %p", $time, rsp_word);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_word.status !== exp_rsp.status) begin
               $display("%0t status mismatch, expected %0d, actual %0d",
                        $time, exp_rsp.status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.is_member !== exp_rsp.is_member) begin
               $display("%0t is_member mismatch, expected %0d, actual %0d",
                        $time, exp_rsp.is_member, rsp_word.is_member);
               error_count++;
            end
            if (rsp_word.entry_total !== exp_rsp.entry_total) begin
               $display("%0t entry_total mismatch, expected %0d, actual %0d",
                        $time, exp_rsp.entry_total, rsp_word.entry_total);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_basic_ops();
      test_fill_to_capacity();
      test_random_traffic(300, 70, 15, 5, 1'b1);
      test_random_traffic(300, 20, 60, 5, 1'b1);
      test_random_traffic(350, 40, 35, 15, 1'b0);
      test_random_traffic(300, 35, 35, 40, 1'b1);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
